[rtl/hlm_pkg.sv]
// ----------------------------------------------------------------------------
// hlm_pkg
// Shared types and constants of the heartbeat liveness monitor.
// ----------------------------------------------------------------------------
package hlm_pkg;

    localparam int unsigned NODES_DEFAULT = 8;
    localparam int unsigned MAX_RESULTS   = 8;
    localparam int unsigned DEAD_CNT_W    = $clog2(MAX_RESULTS + 1);

    localparam logic [31:0] TIMEOUT_RESET  = 32'd100;
    localparam logic [15:0] INTERVAL_RESET = 16'd10;

    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 1'd1;

    localparam logic ACT_TICK      = 1'b0;
    localparam logic ACT_HEARTBEAT = 1'b1;

    typedef struct packed {
        logic       action;
        logic [7:0] node;
    } in_item_t;

    typedef struct packed {
        logic [7:0] node_res;
        logic       became_alive;
        logic       last;
    } out_item_t;

endpackage

[rtl/heartbeat_liveness_monitor.sv]
// ----------------------------------------------------------------------------
// heartbeat_liveness_monitor
// Watchdog over the liveness of up to NODES remote nodes.
// ----------------------------------------------------------------------------
// The input channel carries ticks and heartbeats. A heartbeat stores the
// current time for its node in the last-seen memory and, if the node was
// dead, reports it alive with one result. A tick advances the time counter;
// once the counter passes the next check time, a sweep reads the memory one
// node per cycle, unless held by a stalled receiver, and reports every
// alive node whose silence exceeds the timeout as dead, up to MAX_RESULTS
// per sweep. The final result caused by an item carries last. The
// configuration port is always ready. A new item is accepted only in the
// idle state, so the input waits while a sweep or a report is under way;
// the sweep is paced by the single read port of the last-seen memory.
// Results are held in a pending register and an output register, so a
// stalled receiver only stops the sweep when both are full. After reset
// the time counters are zero, all nodes are dead and the timeout and
// interval take their reset values; the last-seen memory is not cleared,
// since only alive nodes are read and a node becomes alive only by a
// heartbeat that writes its entry.
// ----------------------------------------------------------------------------
module heartbeat_liveness_monitor #(
    parameter int unsigned NODES = hlm_pkg::NODES_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  hlm_pkg::in_item_t             s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output hlm_pkg::out_item_t            m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [hlm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);

    localparam int unsigned IDX_W = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int unsigned CNT_W = $clog2(NODES + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_FLUSH
    } state_t;

    state_t                            state_reg;
    logic [31:0]                       timeout_reg;
    logic [15:0]                       interval_reg;
    logic [31:0]                       now_reg;
    logic [31:0]                       next_check_reg;
    logic [NODES-1:0]                  alive_reg;
    logic [CNT_W-1:0]                  issue_cnt_reg;
    logic                              cmp_valid_reg;
    logic [IDX_W-1:0]                  cmp_idx_reg;
    logic [hlm_pkg::DEAD_CNT_W-1:0]    dead_cnt_reg;
    logic                              pend_valid_reg;
    logic [7:0]                        pend_node_reg;
    logic                              pend_alive_reg;
    logic                              m_valid_reg;
    hlm_pkg::out_item_t                m_data_reg;

    logic [31:0] last_seen_mem [NODES];
    logic [31:0] rd_data_reg;

    logic              in_fire;
    logic              is_tick;
    logic              hb_in_range;
    logic [IDX_W-1:0]  hb_idx;
    logic [31:0]       now_next;
    logic [31:0]       elapsed;
    logic              out_busy;
    logic              hit;
    logic              advance;
    logic              issue_more;
    logic              rd_en;
    logic              mem_we;
    logic              m_load;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign in_fire     = s_valid && s_ready;
    assign is_tick     = (s_data.action == hlm_pkg::ACT_TICK);
    assign hb_in_range = (s_data.node < 8'(NODES));
    assign hb_idx      = s_data.node[IDX_W-1:0];
    assign now_next    = now_reg + 32'd1;
    assign mem_we      = in_fire && !is_tick && hb_in_range;

    assign elapsed  = now_reg - rd_data_reg;
    assign out_busy = m_valid_reg && !m_ready;
    assign hit      = cmp_valid_reg && alive_reg[cmp_idx_reg] && (elapsed > timeout_reg)
                      && (dead_cnt_reg < hlm_pkg::DEAD_CNT_W'(hlm_pkg::MAX_RESULTS));
    assign advance    = !(hit && pend_valid_reg && out_busy);
    assign issue_more = (issue_cnt_reg < CNT_W'(NODES));
    assign rd_en      = (state_reg == ST_SWEEP) && advance && issue_more;
    assign m_load     = ((state_reg == ST_SWEEP) && advance && hit && pend_valid_reg)
                        || ((state_reg == ST_FLUSH) && !out_busy);

    // The memory is only written from the idle state and only read during a
    // sweep, so a read never overlaps a write to the same entry.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            last_seen_mem[hb_idx] <= now_reg;
        end
        if (rd_en) begin
            rd_data_reg <= last_seen_mem[issue_cnt_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            timeout_reg    <= hlm_pkg::TIMEOUT_RESET;
            interval_reg   <= hlm_pkg::INTERVAL_RESET;
            now_reg        <= '0;
            next_check_reg <= '0;
            alive_reg      <= '0;
            issue_cnt_reg  <= '0;
            cmp_valid_reg  <= 1'b0;
            dead_cnt_reg   <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && !m_load) begin
                m_valid_reg <= 1'b0;
            end

            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    hlm_pkg::CFG_TIMEOUT:  timeout_reg  <= cfg_data;
                    hlm_pkg::CFG_INTERVAL: interval_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end

            case (state_reg)
                ST_IDLE: begin
                    if (in_fire) begin
                        if (is_tick) begin
                            now_reg <= now_next;
                            if (now_next > next_check_reg) begin
                                next_check_reg <= next_check_reg + 32'(interval_reg);
                                issue_cnt_reg  <= '0;
                                cmp_valid_reg  <= 1'b0;
                                dead_cnt_reg   <= '0;
                                state_reg      <= ST_SWEEP;
                            end
                        end else if (hb_in_range && !alive_reg[hb_idx]) begin
                            alive_reg[hb_idx] <= 1'b1;
                            pend_valid_reg    <= 1'b1;
                            pend_node_reg     <= s_data.node;
                            pend_alive_reg    <= 1'b1;
                            state_reg         <= ST_FLUSH;
                        end
                    end
                end
                ST_SWEEP: begin
                    if (advance) begin
                        if (hit) begin
                            alive_reg[cmp_idx_reg] <= 1'b0;
                            dead_cnt_reg           <= dead_cnt_reg
                                                      + hlm_pkg::DEAD_CNT_W'(1);
                            if (pend_valid_reg) begin
                                m_valid_reg             <= 1'b1;
                                m_data_reg.node_res     <= pend_node_reg;
                                m_data_reg.became_alive <= pend_alive_reg;
                                m_data_reg.last         <= 1'b0;
                            end
                            pend_valid_reg <= 1'b1;
                            pend_node_reg  <= 8'(cmp_idx_reg);
                            pend_alive_reg <= 1'b0;
                        end
                        if (issue_more) begin
                            cmp_valid_reg <= 1'b1;
                            cmp_idx_reg   <= issue_cnt_reg[IDX_W-1:0];
                            issue_cnt_reg <= issue_cnt_reg + CNT_W'(1);
                        end else begin
                            cmp_valid_reg <= 1'b0;
                            if (!cmp_valid_reg) begin
                                state_reg <= pend_valid_reg ? ST_FLUSH : ST_IDLE;
                            end
                        end
                    end
                end
                ST_FLUSH: begin
                    if (!out_busy) begin
                        m_valid_reg             <= 1'b1;
                        m_data_reg.node_res     <= pend_node_reg;
                        m_data_reg.became_alive <= pend_alive_reg;
                        m_data_reg.last         <= 1'b1;
                        pend_valid_reg          <= 1'b0;
                        state_reg               <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_dead_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        dead_cnt_reg <= hlm_pkg::DEAD_CNT_W'(hlm_pkg::MAX_RESULTS))
        else $error("sweep reported more deaths than allowed");

    a_hit_clears_alive: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWEEP && hit && advance) |=> !alive_reg[$past(cmp_idx_reg)])
        else $error("timed-out node still marked alive");

    a_heartbeat_sets_alive: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |=> alive_reg[$past(hb_idx)])
        else $error("heartbeat did not mark its node alive");

    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("pending result left behind in idle state");

endmodule
